[design/pdu_pkg.sv]
package pdu_pkg;

    // Largest buffer capacity honored; larger register values are clamped.
    localparam int MAX_CAPACITY = 1024;
    localparam int CAP_W        = 11;
    localparam int CNT_W        = 10;
    localparam int ACC_W        = 21;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);
    localparam logic [CAP_W-1:0] CAP_MAX   = CAP_W'(MAX_CAPACITY);

    // Configuration register indexes.
    localparam logic REG_BUFFER_CAPACITY = 1'b0;
    localparam logic REG_OPTIONAL_MODE   = 1'b1;

    // Escape phases.
    localparam logic [1:0] ESC_NONE   = 2'd0;
    localparam logic [1:0] ESC_PCT    = 2'd1;
    localparam logic [1:0] ESC_NIBBLE = 2'd2;

    // Lone dash tracking.
    localparam logic [1:0] DASH_EMPTY = 2'd0;
    localparam logic [1:0] DASH_ONLY  = 2'd1;
    localparam logic [1:0] DASH_OTHER = 2'd2;

    localparam logic [7:0] CHAR_PERCENT = 8'h25;
    localparam logic [7:0] CHAR_DASH    = 8'h2d;

    typedef struct packed {
        logic [1:0]       escape_phase;
        logic [3:0]       high_nibble;
        logic [1:0]       continuations_left;
        logic [1:0]       sequence_length;
        logic [ACC_W-1:0] code_accumulator;
        logic [CNT_W-1:0] byte_count;
        logic             failed_flag;
        logic [1:0]       lone_dash;
    } pdu_state_t;

    typedef struct packed {
        logic             byte_valid;
        logic [7:0]       out_byte;
        logic             done_res;
        logic             accepted;
        logic [CNT_W-1:0] decoded_length;
    } pdu_result_t;

    // Returns {invalid, value} for an ASCII hex digit in either case.
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b0, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b0, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b0, 4'(c - 8'h37)};
        end else begin
            r = 5'h10;
        end
        return r;
    endfunction

endpackage

[design/percent_decode_utf8_check_core.sv]
// Percent-decoding string checker with UTF-8 validation.
//
// The input channel (in_valid/in_ready) carries one beat per raw byte of an
// encoded string: has_byte, text_byte and last_byte. A beat with has_byte low
// and last_byte high ends an empty string; one with both low is an idle beat.
// Every input beat yields exactly one output beat (out_valid/out_ready) with
// the decoded byte, if any, and on the last beat the accept flag and length.
// Consumers drop the bytes of a string that ends rejected.
//
// The block is a two-register pipeline: an input register, then the decode
// and check logic, then the result register. While the receiver keeps
// out_ready high, the block sustains one beat per clock cycle. When the
// receiver stalls, the result register holds and the input register fills;
// in_ready drops only when both are full, and rises again in the cycle the
// result is taken.
//
// Reset empties both registers and per-string state, sets capacity to 64 and
// optional mode off. The user writes the configuration port (cfg_we, cfg_index,
// cfg_data) only while no string is in flight; the block does not enforce it.
module percent_decode_utf8_check_core
    import pdu_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,

    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [CAP_W-1:0] cfg_data,

    input  logic             in_valid,
    output logic             in_ready,
    input  logic             has_byte,
    input  logic [7:0]       text_byte,
    input  logic             last_byte,

    output logic             out_valid,
    input  logic             out_ready,
    output logic             byte_valid,
    output logic [7:0]       out_byte,
    output logic             done_res,
    output logic             accepted,
    output logic [CNT_W-1:0] decoded_length
);

    logic [CAP_W-1:0] capacity_reg;
    logic             optional_reg;

    logic             s1_valid_reg;
    logic             s1_has_reg;
    logic [7:0]       s1_byte_reg;
    logic             s1_last_reg;

    pdu_state_t       state_reg;
    pdu_state_t       state_next;
    pdu_result_t      result_next;
    pdu_result_t      result_reg;
    logic             out_valid_reg;

    logic             load_out;

    // The result register takes a new beat when it is empty or being drained.
    assign load_out = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || load_out;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            capacity_reg <= CAP_RESET;
            optional_reg <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_BUFFER_CAPACITY: capacity_reg <= cfg_data;
                REG_OPTIONAL_MODE:   optional_reg <= cfg_data[0];
                default:             ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end else begin
            if (in_ready) begin
                s1_valid_reg <= in_valid;
            end
            if (load_out) begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (in_valid && in_ready) begin
            s1_has_reg  <= has_byte;
            s1_byte_reg <= text_byte;
            s1_last_reg <= last_byte;
        end
        if (load_out) begin
            result_reg <= result_next;
        end
    end

    pdu_step u_step (
        .state_q         (state_reg),
        .has_byte        (s1_has_reg),
        .text_byte       (s1_byte_reg),
        .last_byte       (s1_last_reg),
        .buffer_capacity (capacity_reg),
        .optional_mode   (optional_reg),
        .state_d         (state_next),
        .result          (result_next)
    );

    assign out_valid      = out_valid_reg;
    assign byte_valid     = result_reg.byte_valid;
    assign out_byte       = result_reg.out_byte;
    assign done_res       = result_reg.done_res;
    assign accepted       = result_reg.accepted;
    assign decoded_length = result_reg.decoded_length;

    // A beat moved into the result register is always presented next cycle.
    a_load_presents: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> out_valid)
        else $error("result register lost a beat");

    // The last beat of a string leaves the per-string state cleared.
    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        load_out && s1_last_reg |=> state_reg.byte_count == '0 &&
            state_reg.escape_phase == ESC_NONE && !state_reg.failed_flag)
        else $error("string state not cleared at end of string");

    // An empty input register never blocks the input channel.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> in_ready)
        else $error("input stalled with empty input register");

    // A nonzero stored byte count never reaches the usable capacity.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.byte_count == '0 ||
        ({1'b0, state_reg.byte_count} < capacity_reg &&
         {1'b0, state_reg.byte_count} < CAP_MAX))
        else $error("byte count beyond buffer capacity");

endmodule

[design/pdu_step.sv]
module pdu_step
    import pdu_pkg::*;
(
    input  pdu_state_t       state_q,
    input  logic             has_byte,
    input  logic [7:0]       text_byte,
    input  logic             last_byte,
    input  logic [CAP_W-1:0] buffer_capacity,
    input  logic             optional_mode,
    output pdu_state_t       state_d,
    output pdu_result_t      result
);

    always_comb begin
        pdu_state_t       nxt;
        logic             have_dec;
        logic [7:0]       dec;
        logic [4:0]       hex;
        logic [CAP_W-1:0] cap_eff;
        logic [CAP_W-1:0] count_plus;
        logic             utf_ok;
        logic [ACC_W-1:0] acc_new;
        logic [1:0]       cont_new;
        logic             ok;

        nxt        = state_q;
        have_dec   = 1'b0;
        dec        = 8'h00;
        hex        = hex_digit(text_byte);
        cap_eff    = (buffer_capacity > CAP_MAX) ? CAP_MAX : buffer_capacity;
        count_plus = {1'b0, state_q.byte_count} + CAP_W'(1);
        utf_ok     = 1'b1;
        acc_new    = {state_q.code_accumulator[ACC_W-7:0], dec[5:0]};
        cont_new   = state_q.continuations_left - 2'd1;
        ok         = 1'b0;
        result     = '0;

        if (has_byte) begin
            if (state_q.lone_dash == DASH_EMPTY && text_byte == CHAR_DASH) begin
                nxt.lone_dash = DASH_ONLY;
            end else begin
                nxt.lone_dash = DASH_OTHER;
            end

            if (state_q.escape_phase == ESC_PCT) begin
                if (hex[4]) begin
                    nxt.failed_flag  = 1'b1;
                    nxt.escape_phase = ESC_NONE;
                end else begin
                    nxt.high_nibble  = hex[3:0];
                    nxt.escape_phase = ESC_NIBBLE;
                end
            end else if (state_q.escape_phase == ESC_NIBBLE) begin
                nxt.escape_phase = ESC_NONE;
                if (hex[4]) begin
                    nxt.failed_flag = 1'b1;
                end else begin
                    dec      = {state_q.high_nibble, hex[3:0]};
                    have_dec = 1'b1;
                end
            end else if (text_byte == CHAR_PERCENT) begin
                nxt.escape_phase = ESC_PCT;
            end else begin
                dec      = text_byte;
                have_dec = 1'b1;
            end

            acc_new = {state_q.code_accumulator[ACC_W-7:0], dec[5:0]};

            if (have_dec && !nxt.failed_flag) begin
                if (count_plus >= cap_eff) begin
                    nxt.failed_flag = 1'b1;
                end else begin
                    nxt.byte_count    = state_q.byte_count + CNT_W'(1);
                    result.byte_valid = 1'b1;
                    result.out_byte   = dec;

                    // UTF-8 check of the decoded byte.
                    if (state_q.continuations_left == 2'd0) begin
                        if (!dec[7]) begin
                            utf_ok = !(dec < 8'h20 || dec == 8'h7f);
                        end else if (dec >= 8'hc2 && dec <= 8'hdf) begin
                            nxt.code_accumulator   = ACC_W'(dec[4:0]);
                            nxt.continuations_left = 2'd1;
                            nxt.sequence_length    = 2'd1;
                        end else if (dec >= 8'he0 && dec <= 8'hef) begin
                            nxt.code_accumulator   = ACC_W'(dec[3:0]);
                            nxt.continuations_left = 2'd2;
                            nxt.sequence_length    = 2'd2;
                        end else if (dec >= 8'hf0 && dec <= 8'hf4) begin
                            nxt.code_accumulator   = ACC_W'(dec[2:0]);
                            nxt.continuations_left = 2'd3;
                            nxt.sequence_length    = 2'd3;
                        end else begin
                            utf_ok = 1'b0;
                        end
                    end else if (dec[7:6] != 2'b10) begin
                        utf_ok = 1'b0;
                    end else begin
                        nxt.code_accumulator   = acc_new;
                        nxt.continuations_left = cont_new;
                        if (cont_new == 2'd0) begin
                            if ((state_q.sequence_length == 2'd2 &&
                                 acc_new < ACC_W'(24'h000800)) ||
                                (state_q.sequence_length == 2'd3 &&
                                 acc_new < ACC_W'(24'h010000)) ||
                                (acc_new >= ACC_W'(24'h00d800) &&
                                 acc_new <= ACC_W'(24'h00dfff)) ||
                                acc_new > ACC_W'(24'h10ffff)) begin
                                utf_ok = 1'b0;
                            end
                        end
                    end

                    if (!utf_ok) begin
                        nxt.failed_flag = 1'b1;
                    end
                end
            end
        end

        if (last_byte) begin
            ok = !nxt.failed_flag && nxt.escape_phase == ESC_NONE &&
                 nxt.continuations_left == 2'd0 &&
                 !(!optional_mode && nxt.byte_count == '0);
            result.done_res       = 1'b1;
            result.decoded_length = nxt.byte_count;
            if (optional_mode && nxt.lone_dash == DASH_ONLY) begin
                ok                    = 1'b1;
                result.decoded_length = '0;
            end
            result.accepted = ok;
            nxt             = '0;
        end

        state_d = nxt;
    end

endmodule

[test/percent_decode_utf8_check_core_test.sv]
module percent_decode_utf8_check_core_test
    import pdu_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [7:0] octet_t;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic             cfg_index;
    logic [CAP_W-1:0] cfg_data;
    logic             in_valid;
    logic             in_ready;
    logic             has_byte;
    logic [7:0]       text_byte;
    logic             last_byte;
    logic             out_valid;
    logic             out_ready;
    logic             byte_valid;
    logic [7:0]       out_byte;
    logic             done_res;
    logic             accepted;
    logic [CNT_W-1:0] decoded_length;

    percent_decode_utf8_check_core dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .has_byte       (has_byte),
        .text_byte      (text_byte),
        .last_byte      (last_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .byte_valid     (byte_valid),
        .out_byte       (out_byte),
        .done_res       (done_res),
        .accepted       (accepted),
        .decoded_length (decoded_length)
    );

    // Decoder mirror. These hold our own view of the configuration registers
    // and of the per-string state; they advance once per accepted input beat.
    logic [CAP_W-1:0] model_capacity;
    logic             model_optional;
    logic [1:0]       esc_phase;
    logic [3:0]       hi_nibble;
    logic [1:0]       cont_left;
    logic [1:0]       seq_len;
    logic [ACC_W-1:0] code_point;
    int               stored;
    logic             failed;
    logic [1:0]       dash_state;

    // Results the block still owes us, oldest first.
    pdu_result_t expected_results[$];

    // Raw bytes of the encoded string that the next send_text call pushes.
    octet_t text_q[$];

    int  mismatches  = 0;
    int  beats_sent  = 0;
    // When set, neither the sender nor the receiver inserts any idle cycles.
    bit  steady_flow = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop in case the block hangs or a result never shows up.
    initial
    begin
        #10_000_000;
        $display("percent_decode_utf8_check_core verification failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Decoder mirror
    // ------------------------------------------------------------------

    function automatic void clear_string_state();
        esc_phase  = ESC_NONE;
        hi_nibble  = '0;
        cont_left  = '0;
        seq_len    = '0;
        code_point = '0;
        stored     = 0;
        failed     = 1'b0;
        dash_state = DASH_EMPTY;
    endfunction

    // Value of an ASCII hex digit in either case, or 16 for anything else.
    function automatic int nibble_of(input octet_t c);
        if (c >= 8'h30 && c <= 8'h39) return int'(c - 8'h30);
        if (c >= 8'h61 && c <= 8'h66) return int'(c - 8'h61) + 10;
        if (c >= 8'h41 && c <= 8'h46) return int'(c - 8'h41) + 10;
        return 16;
    endfunction

    // Runs one decoded byte through the UTF-8 rules. Returns 0 when the byte
    // makes the string invalid: a control character, a bad lead byte, a bad
    // continuation, or a completed sequence that is overlong, a surrogate or
    // beyond the Unicode range.
    function automatic bit utf8_step(input octet_t b);
        if (cont_left == 2'd0) begin
            if (b < 8'h80) return !(b < 8'h20 || b == 8'h7f);
            if (b >= 8'hc2 && b <= 8'hdf) begin
                code_point = ACC_W'(b[4:0]);
                cont_left  = 2'd1;
            end else if (b >= 8'he0 && b <= 8'hef) begin
                code_point = ACC_W'(b[3:0]);
                cont_left  = 2'd2;
            end else if (b >= 8'hf0 && b <= 8'hf4) begin
                code_point = ACC_W'(b[2:0]);
                cont_left  = 2'd3;
            end else begin
                return 1'b0;
            end
            seq_len = cont_left;
            return 1'b1;
        end
        if (b[7:6] != 2'b10) return 1'b0;
        code_point = {code_point[ACC_W-7:0], b[5:0]};
        cont_left  = cont_left - 2'd1;
        if (cont_left != 2'd0) return 1'b1;
        if ((seq_len == 2'd2 && code_point < 21'h800) ||
            (seq_len == 2'd3 && code_point < 21'h10000) ||
            (code_point >= 21'hd800 && code_point <= 21'hdfff) ||
            code_point > 21'h10ffff) return 1'b0;
        return 1'b1;
    endfunction

    // Advances the mirror by one input beat and returns the result beat the
    // block must produce for it.
    function automatic pdu_result_t predict_beat(input logic has, input octet_t c,
                                                 input logic last);
        pdu_result_t r;
        int          cap;
        int          digit;
        bit          have_dec;
        bit          ok;
        octet_t      dec;
        r        = '0;
        have_dec = 1'b0;
        dec      = '0;
        cap      = (model_capacity > CAP_MAX) ? MAX_CAPACITY : int'(model_capacity);
        if (has) begin
            if (dash_state == DASH_EMPTY && c == CHAR_DASH) dash_state = DASH_ONLY;
            else dash_state = DASH_OTHER;

            if (esc_phase == ESC_PCT) begin
                digit = nibble_of(c);
                if (digit > 15) begin
                    failed    = 1'b1;
                    esc_phase = ESC_NONE;
                end else begin
                    hi_nibble = digit[3:0];
                    esc_phase = ESC_NIBBLE;
                end
            end else if (esc_phase == ESC_NIBBLE) begin
                digit     = nibble_of(c);
                esc_phase = ESC_NONE;
                if (digit > 15) begin
                    failed = 1'b1;
                end else begin
                    dec      = {hi_nibble, digit[3:0]};
                    have_dec = 1'b1;
                end
            end else if (c == CHAR_PERCENT) begin
                esc_phase = ESC_PCT;
            end else begin
                dec      = c;
                have_dec = 1'b1;
            end

            // A byte that would leave no room for the terminator kills the
            // string and is not emitted; once failed, nothing is emitted.
            if (have_dec && !failed) begin
                if (stored + 1 >= cap) begin
                    failed = 1'b1;
                end else begin
                    stored++;
                    r.byte_valid = 1'b1;
                    r.out_byte   = dec;
                    if (!utf8_step(dec)) failed = 1'b1;
                end
            end
        end
        if (last) begin
            ok = !failed && esc_phase == ESC_NONE && cont_left == 2'd0 &&
                 !(!model_optional && stored == 0);
            r.done_res       = 1'b1;
            r.decoded_length = (stored > 1023) ? '1 : CNT_W'(stored);
            // A string that is exactly one raw dash means "empty" in optional
            // mode, whatever else went wrong with it.
            if (model_optional && dash_state == DASH_ONLY) begin
                ok               = 1'b1;
                r.decoded_length = '0;
            end
            r.accepted = ok;
            clear_string_state();
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Pacing and the two channels
    // ------------------------------------------------------------------

    // Idle length for either side: usually none, sometimes a short gap,
    // now and then a long pause.
    function automatic int idle_length();
        int roll;
        if (steady_flow) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 65) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 24);
    endfunction

    // Receiver side: out_ready drops for random stretches. Handshakes are
    // sampled at the falling edge, where every signal is settled, and take
    // effect at the rising edge that follows.
    initial
    begin : sink_pacing
        int stall;
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            stall = idle_length();
            if (stall == 0) begin
                out_ready <= 1'b1;
            end else begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
                out_ready <= 1'b1;
            end
        end
    end

    // Result checker: every output beat is compared with the oldest
    // expectation, field by field.
    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    initial
    begin : result_checker
        pdu_result_t want;
        forever
        begin
            @(negedge clk);
            if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
                if (expected_results.size() == 0) begin
                    $error("output beat with no expected result pending");
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("byte_valid", 32'(want.byte_valid), 32'(byte_valid));
                    check_field("out_byte", 32'(want.out_byte), 32'(out_byte));
                    check_field("done_res", 32'(want.done_res), 32'(done_res));
                    check_field("accepted", 32'(want.accepted), 32'(accepted));
                    check_field("decoded_length", 32'(want.decoded_length),
                                32'(decoded_length));
                end
            end
        end
    end

    // Sends one input beat. Valid stays high from one beat to the next when
    // there is no gap, so it is only lowered at the start of a gap.
    task automatic send_beat(input logic has, input octet_t ch, input logic last);
        int gap;
        bit taken;
        gap = idle_length();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        has_byte  <= has;
        text_byte <= ch;
        last_byte <= last;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = in_ready;
            if (taken) begin
                expected_results.push_back(predict_beat(has, ch, last));
                beats_sent++;
            end
            @(posedge clk);
        end
    endtask

    // Sends text_q as one string, with an occasional idle beat in between.
    // An empty text_q becomes the empty-string beat.
    task automatic send_text();
        if (text_q.size() == 0) begin
            send_beat(1'b0, 8'($urandom), 1'b1);
        end else begin
            for (int i = 0; i < text_q.size(); i++)
            begin
                if (i > 0 && $urandom_range(0, 99) < 3) send_beat(1'b0, 8'($urandom), 1'b0);
                send_beat(1'b1, text_q[i], i == text_q.size() - 1);
            end
        end
    endtask

    // Stops input, waits for every pending result, then lets the pipeline drain.
    task automatic settle_block();
        in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Register writes happen only with the block idle; the mirror takes the
    // same value at the same point.
    task automatic write_register(input logic idx, input logic [CAP_W-1:0] value);
        settle_block();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == REG_BUFFER_CAPACITY) model_capacity = value;
        else model_optional = value[0];
    endtask

    // ------------------------------------------------------------------
    // String builders
    // ------------------------------------------------------------------

    function automatic octet_t hex_char(input logic [3:0] n);
        if (n < 4'd10) return 8'h30 + 8'(n);
        return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
    endfunction

    // Appends one decoded byte, raw or as an escape in random case. A percent
    // sign always has to go out escaped.
    function automatic void put_byte(input octet_t b);
        if (b == CHAR_PERCENT || $urandom_range(0, 99) < 25) begin
            text_q.push_back(CHAR_PERCENT);
            text_q.push_back(hex_char(b[7:4]));
            text_q.push_back(hex_char(b[3:0]));
        end else begin
            text_q.push_back(b);
        end
    endfunction

    // Encodes a code point in a forced number of bytes (which makes overlong
    // forms possible) and appends the first keep bytes of it.
    function automatic void put_utf8(input logic [20:0] cp, input int nbytes, input int keep);
        octet_t seq[4];
        case (nbytes)
            1: seq[0] = {1'b0, cp[6:0]};
            2:
            begin
                seq[0] = {3'b110, cp[10:6]};
                seq[1] = {2'b10, cp[5:0]};
            end
            3:
            begin
                seq[0] = {4'b1110, cp[15:12]};
                seq[1] = {2'b10, cp[11:6]};
                seq[2] = {2'b10, cp[5:0]};
            end
            default:
            begin
                seq[0] = {5'b11110, cp[20:18]};
                seq[1] = {2'b10, cp[17:12]};
                seq[2] = {2'b10, cp[11:6]};
                seq[3] = {2'b10, cp[5:0]};
            end
        endcase
        for (int i = 0; i < keep; i++) put_byte(seq[i]);
    endfunction

    // Mostly well-formed characters, with a steady share of each kind of
    // UTF-8 violation mixed in.
    function automatic void put_random_char();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 45)      put_byte(8'($urandom_range(8'h20, 8'h7e)));
        else if (roll < 55) put_utf8(21'($urandom_range(21'h80, 21'h7ff)), 2, 2);
        else if (roll < 65) put_utf8(21'($urandom_range(21'h800, 21'hffff)), 3, 3);
        else if (roll < 71) put_utf8(21'($urandom_range(21'h10000, 21'h10ffff)), 4, 4);
        else if (roll < 72) put_utf8(21'($urandom_range(0, 21'h7f)), 2, 2);
        else if (roll < 74) put_utf8(21'($urandom_range(0, 21'h7ff)), 3, 3);
        else if (roll < 76) put_utf8(21'($urandom_range(0, 21'hffff)), 4, 4);
        else if (roll < 78) put_utf8(21'($urandom_range(21'hd800, 21'hdfff)), 3, 3);
        else if (roll < 80) put_utf8(21'($urandom_range(21'h110000, 21'h1fffff)), 4, 4);
        else if (roll < 83) put_byte(roll[0] ? 8'h7f : 8'($urandom_range(0, 8'h1f)));
        else if (roll < 87) put_utf8(21'($urandom_range(21'h800, 21'h10ffff)), 4,
                                     $urandom_range(1, 3));
        else                put_byte(8'($urandom));
    endfunction

    // A percent sign followed by a non-hex digit, by one good digit and a bad
    // one, or by nothing at all.
    function automatic void put_broken_escape();
        octet_t junk;
        junk = $urandom_range(0, 1) ? 8'($urandom_range(8'h67, 8'h7a))
                                    : 8'($urandom_range(8'h00, 8'h2f));
        text_q.push_back(CHAR_PERCENT);
        case ($urandom_range(0, 2))
            0: text_q.push_back(junk);
            1:
            begin
                text_q.push_back(hex_char(4'($urandom)));
                text_q.push_back(junk);
            end
            default: ;
        endcase
    endfunction

    function automatic void build_random_text();
        int roll;
        int chars;
        text_q.delete();
        roll = $urandom_range(0, 99);
        if (roll < 4) return;
        if (roll < 8) begin
            text_q.push_back(CHAR_DASH);
            return;
        end
        chars = (roll < 90) ? $urandom_range(1, 6) : $urandom_range(7, 24);
        for (int i = 0; i < chars; i++)
        begin
            if ($urandom_range(0, 99) < 4) put_broken_escape();
            else put_random_char();
        end
    endfunction

    // Long runs of plain printable characters, no escapes.
    function automatic void fill_printable(input int count);
        octet_t ch;
        text_q.delete();
        for (int i = 0; i < count; i++)
        begin
            ch = 8'($urandom_range(8'h20, 8'h7e));
            if (ch == CHAR_PERCENT) ch = CHAR_DASH;
            text_q.push_back(ch);
        end
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Escapes in both cases, a bad first and second digit, the bytes after a
    // failure, and strings that end inside an escape.
    task automatic test_escape_decoding();
        text_q = '{"%", "4", "a", "%", "7", "E"};
        send_text();
        text_q = '{"%", "g", "a"};
        send_text();
        text_q = '{"%", "F", "z"};
        send_text();
        text_q = '{"a", "%", "4"};
        send_text();
    endtask

    // A good three-byte sequence, a bad lead byte, a truncated sequence,
    // the zero byte, a surrogate and a code point past the top of Unicode.
    task automatic test_utf8_rules();
        text_q = '{"%", "e", "2", 8'h82, 8'hac};
        send_text();
        text_q = '{8'hff, "A"};
        send_text();
        text_q = '{8'he2, 8'h82};
        send_text();
        text_q = '{8'h00};
        send_text();
        text_q = '{8'hed, 8'ha0, 8'h80};
        send_text();
        text_q = '{8'hf4, 8'h90, 8'h80, 8'h80};
        send_text();
    endtask

    // Empty string without optional mode, idle beats inside a string, and a
    // dash that is just an ordinary character while optional mode is off.
    task automatic test_empty_and_idle();
        text_q.delete();
        send_text();
        send_beat(1'b1, "a", 1'b0);
        send_beat(1'b0, 8'hff, 1'b0);
        send_beat(1'b0, 8'h00, 1'b0);
        send_beat(1'b1, "b", 1'b1);
        text_q = '{CHAR_DASH};
        send_text();
    endtask

    // Small capacities, zero included, where the terminator leaves room for
    // no byte or only a few.
    task automatic test_capacity_edges();
        for (int cap = 0; cap <= 4; cap++)
        begin
            write_register(REG_BUFFER_CAPACITY, CAP_W'(cap));
            text_q = '{"a"};
            send_text();
            text_q = '{"a", "b", "c"};
            send_text();
            repeat (2)
            begin
                build_random_text();
                send_text();
            end
        end
    endtask

    // The largest honored capacity and a register value past it must both
    // carry ordinary long strings.
    task automatic test_capacity_clamp();
        write_register(REG_BUFFER_CAPACITY, CAP_MAX);
        fill_printable(30);
        send_text();
        write_register(REG_BUFFER_CAPACITY, '1);
        fill_printable(30);
        send_text();
    endtask

    // Optional mode: empty strings pass, a lone raw dash passes as empty even
    // when the capacity rejects it, an escaped dash is a real character.
    task automatic test_optional_mode();
        write_register(REG_BUFFER_CAPACITY, CAP_RESET);
        write_register(REG_OPTIONAL_MODE, {10'($urandom), 1'b1});
        text_q = '{CHAR_DASH};
        send_text();
        text_q.delete();
        send_text();
        text_q = '{CHAR_DASH, CHAR_DASH};
        send_text();
        text_q = '{"%", "2", "d"};
        send_text();
        write_register(REG_BUFFER_CAPACITY, CAP_W'(1));
        text_q = '{CHAR_DASH};
        send_text();
        write_register(REG_BUFFER_CAPACITY, CAP_RESET);
        repeat (10)
        begin
            build_random_text();
            send_text();
        end
        write_register(REG_OPTIONAL_MODE, {10'($urandom), 1'b0});
    endtask

    // Random strings over several register settings; two of the phases run
    // with no idle cycles on either side.
    task automatic test_random_traffic();
        int               phase_end;
        logic [CAP_W-1:0] cap;
        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: cap = CAP_RESET;
                1: cap = CAP_W'($urandom_range(2, 12));
                2: cap = CAP_MAX;
                3: cap = CAP_W'($urandom_range(13, 300));
                4: cap = '1;
                default: cap = CAP_W'($urandom_range(1, 8));
            endcase
            write_register(REG_BUFFER_CAPACITY, cap);
            write_register(REG_OPTIONAL_MODE, {10'($urandom), 1'($urandom)});
            steady_flow = (phase == 2 || phase == 5);
            phase_end   = beats_sent + 40;
            while (beats_sent < phase_end)
            begin
                build_random_text();
                send_text();
            end
        end
        steady_flow = 1'b0;
    endtask

    initial
    begin
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = REG_BUFFER_CAPACITY;
        cfg_data  = '0;
        in_valid  = 1'b0;
        has_byte  = 1'b0;
        text_byte = '0;
        last_byte = 1'b0;
        model_capacity = CAP_RESET;
        model_optional = 1'b0;
        clear_string_state();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_escape_decoding();
        test_utf8_rules();
        test_empty_and_idle();
        test_capacity_edges();
        test_capacity_clamp();
        test_optional_mode();
        test_random_traffic();

        settle_block();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("percent_decode_utf8_check_core verification clean");
        end
        else
        begin
            $display("percent_decode_utf8_check_core verification failed");
        end
        $finish;
    end

endmodule

[percent_decode_utf8_check_core.f]
design/pdu_pkg.sv
design/pdu_step.sv
design/percent_decode_utf8_check_core.sv
test/percent_decode_utf8_check_core_test.sv
